// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// Types and constants of the Sobel edge magnitude core.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int DIM_W       = 11;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W       = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int SAT_LIMIT   = 65280;
    localparam int PADDR_W     = 3;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_edge;
        logic [7:0] green_edge;
        logic [7:0] blue_edge;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [COL_W-1:0] col;
        logic             produce;
        logic             last;
        logic             row_first;
        logic             row_last;
        logic             col_first;
        logic             col_last;
    } t_job;

endpackage

// ===== hw/rtl/sobel_edge_magnitude_rgb_core.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_core
// Streaming 3x3 Sobel gradient magnitude on RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Each accepted item passes the back end's line buffer read and window shift;
// one that yields a result then goes through Sobel sums, squares, 8 root steps
// and the result load, which waits for a free output. The back end takes one
// item at a time, so the bit-at-a-time square root bounds the rate. A four-entry
// queue lets the front accept while the back end works. Results lag their
// pixel by frame_width+1 items; send frame_width+1 flush items (mode 1) after
// the last pixel to drain the frame, the final result carries frame_last.
// Writing either register restarts the frame.
`include "assert_macros.svh"

module sobel_edge_magnitude_rgb_core
    import sem_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_job front_job;
    t_job head_job;

    sem_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (front_job)
    );

    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    sem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    `ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, q_push && q_full)
    `ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, q_pop && q_empty)
    `ASSERT_CLK(a_last_restarts, i_clk, i_rst_n, (q_push && front_job.last) |=> (!q_push || (front_job.col == '0)))

endmodule

// ===== hw/rtl/sem_ram.sv =====
// ----------------------------------------------------------------------------
// sem_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/sem_queue.sv =====
// ----------------------------------------------------------------------------
// sem_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module sem_queue
    import sem_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_job               r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [PTR_W:0]     r_count, n_count;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr  = r_wptr + 1'b1;
            n_count = n_count + 1'b1;
        end
        if (i_pop) begin
            n_rptr  = r_rptr + 1'b1;
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

endmodule

// ===== hw/rtl/sem_front.sv =====
// ----------------------------------------------------------------------------
// sem_front
// Register port, frame counters and item classification.
// ----------------------------------------------------------------------------
module sem_front
    import sem_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    input  logic               i_q_full,
    output logic               o_push,
    output t_job               o_job
);

    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [COL_W-1:0]  r_out_col;
    logic [OROW_W-1:0] r_out_row;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              cfg_wr;
    logic              accept;
    logic              in_range;
    logic              keep;
    logic              produce;
    logic              in_col_end;
    logic              out_col_end;
    logic              out_row_first;
    logic              out_row_end;
    logic              frame_end;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    assign o_in_ready    = !i_q_full;
    assign accept        = i_in_valid && o_in_ready;
    assign in_range      = 32'(r_in_row) < 32'(h_eff);
    assign keep          = i_in_data.mode ? !in_range : in_range;
    assign produce       = (32'(r_in_row) >= 32'd2) ||
                           ((32'(r_in_row) == 32'd1) && (r_in_col != '0));
    assign in_col_end    = 32'(r_in_col) == 32'(w_eff) - 32'd1;
    assign out_col_end   = 32'(r_out_col) == 32'(w_eff) - 32'd1;
    assign out_row_first = (r_out_row == '0);
    assign out_row_end   = 32'(r_out_row) == 32'(h_eff) - 32'd1;
    assign frame_end     = produce && out_col_end && out_row_end;
    assign o_push        = accept && keep;

    always_comb begin
        o_job           = '0;
        o_job.px        = i_in_data.mode ? '0
                        : {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
        o_job.col       = r_in_col;
        o_job.produce   = produce;
        o_job.last      = frame_end;
        o_job.row_first = out_row_first;
        o_job.row_last  = out_row_end;
        o_job.col_first = (r_out_col == '0);
        o_job.col_last  = out_col_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(1024);
            r_frame_height <= DIM_W'(1024);
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[DIM_W-1:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (o_push) begin
            if (frame_end) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (in_col_end) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 1'b1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
                if (produce) begin
                    if (out_col_end) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 1'b1;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/sem_back.sv =====
// ----------------------------------------------------------------------------
// sem_back
// Line buffer, 3x3 window, Sobel sums, iterative rounded root, result register.
// ----------------------------------------------------------------------------
module sem_back
    import sem_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_q_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WIN  = 6'b000010,
        S_GRAD = 6'b000100,
        S_SQ   = 6'b001000,
        S_ROOT = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state              r_state;
    t_job                r_job;
    logic [PIX_W-1:0]    r_win [3][3];
    logic signed [11:0]  r_gx [3];
    logic signed [11:0]  r_gy [3];
    logic [16:0]         r_s [3];
    logic [16:0]         r_r [3];
    logic                r_sat [3];
    logic [15:0]         r_bit;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [2*PIX_W-1:0]  rd_data;
    logic                ram_we;
    logic [7:0]          tap [3][3][3];
    logic signed [11:0]  gx [3];
    logic signed [11:0]  gy [3];
    logic [21:0]         sum [3];
    logic [7:0]          root [3];
    logic                out_free;

    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign ram_we   = (r_state == S_WIN);
    assign out_free = !r_out_valid || i_out_ready;

    sem_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_job.col),
        .i_wdata ({r_job.px, rd_data[2*PIX_W-1:PIX_W]}),
        .i_raddr (i_job.col),
        .o_rdata (rd_data)
    );

    always_comb begin
        for (int rr = 0; rr < 3; rr++) begin
            for (int cc = 0; cc < 3; cc++) begin
                for (int ch = 0; ch < 3; ch++) begin
                    tap[rr][cc][ch] = r_win[rr][cc][23-8*ch -: 8];
                    if ((rr == 0 && r_job.row_first) || (rr == 2 && r_job.row_last) ||
                        (cc == 0 && r_job.col_first) || (cc == 2 && r_job.col_last)) begin
                        tap[rr][cc][ch] = '0;
                    end
                end
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            gx[ch] = 12'(signed'({4'b0, tap[0][2][ch]}))
                   + 12'(signed'({3'b0, tap[1][2][ch], 1'b0}))
                   + 12'(signed'({4'b0, tap[2][2][ch]}))
                   - 12'(signed'({4'b0, tap[0][0][ch]}))
                   - 12'(signed'({3'b0, tap[1][0][ch], 1'b0}))
                   - 12'(signed'({4'b0, tap[2][0][ch]}));
            gy[ch] = 12'(signed'({4'b0, tap[2][0][ch]}))
                   + 12'(signed'({3'b0, tap[2][1][ch], 1'b0}))
                   + 12'(signed'({4'b0, tap[2][2][ch]}))
                   - 12'(signed'({4'b0, tap[0][0][ch]}))
                   - 12'(signed'({3'b0, tap[0][1][ch], 1'b0}))
                   - 12'(signed'({4'b0, tap[0][2][ch]}));
            sum[ch] = unsigned'(22'(r_gx[ch]) * 22'(r_gx[ch]))
                    + unsigned'(22'(r_gy[ch]) * 22'(r_gy[ch]));
            if (r_sat[ch]) begin
                root[ch] = 8'hFF;
            end else if (r_s[ch] > r_r[ch]) begin
                root[ch] = r_r[ch][7:0] + 8'd1;
            end else begin
                root[ch] = r_r[ch][7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= S_WIN;
                    end
                end
                S_WIN:  r_state <= r_job.produce ? S_GRAD : S_IDLE;
                S_GRAD: r_state <= S_SQ;
                S_SQ:   r_state <= S_ROOT;
                S_ROOT: begin
                    if (r_bit == 16'd1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end

        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_WIN) begin
            for (int rr = 0; rr < 3; rr++) begin
                r_win[rr][0] <= r_win[rr][1];
                r_win[rr][1] <= r_win[rr][2];
            end
            r_win[0][2] <= rd_data[PIX_W-1:0];
            r_win[1][2] <= rd_data[2*PIX_W-1:PIX_W];
            r_win[2][2] <= r_job.px;
        end
        if (r_state == S_GRAD) begin
            r_gx <= gx;
            r_gy <= gy;
        end
        if (r_state == S_SQ) begin
            r_bit <= 16'h4000;
            for (int ch = 0; ch < 3; ch++) begin
                r_s[ch]   <= sum[ch][16:0];
                r_r[ch]   <= '0;
                r_sat[ch] <= 32'(sum[ch]) > 32'(SAT_LIMIT);
            end
        end
        if (r_state == S_ROOT) begin
            r_bit <= r_bit >> 2;
            for (int ch = 0; ch < 3; ch++) begin
                if (r_s[ch] >= r_r[ch] + {1'b0, r_bit}) begin
                    r_s[ch] <= r_s[ch] - (r_r[ch] + {1'b0, r_bit});
                    r_r[ch] <= (r_r[ch] >> 1) + {1'b0, r_bit};
                end else begin
                    r_r[ch] <= r_r[ch] >> 1;
                end
            end
        end
        if (r_state == S_DONE && out_free) begin
            r_out.red_edge   <= root[0];
            r_out.green_edge <= root[1];
            r_out.blue_edge  <= root[2];
            r_out.frame_last <= r_job.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
